@@ design/text_mode_console_writer_core_macros.svh @@
// Assertion macros for the checker file of the console writer.
// Depends on nothing; included by the checker that is bound to the top level.
`ifndef TEXT_MODE_CONSOLE_WRITER_CORE_MACROS_SVH
`define TEXT_MODE_CONSOLE_WRITER_CORE_MACROS_SVH

// Checked at every rising edge while reset is released.
`define TMCW_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define TMCW_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/tmcw_pkg.sv @@
// Package of the text mode console writer: screen geometry, character codes,
// command and state types shared by the front, queue and back modules.
// Depends on nothing.
package tmcw_pkg;

    localparam int unsigned COLUMNS     = 80;
    localparam int unsigned ROWS        = 25;
    localparam int unsigned SCREEN_SIZE = COLUMNS * ROWS;
    localparam int unsigned ADDR_W      = $clog2(SCREEN_SIZE);
    localparam int unsigned COL_W       = $clog2(COLUMNS);

    localparam logic [ADDR_W-1:0] LAST_ROW  = ADDR_W'(SCREEN_SIZE - COLUMNS);
    localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(SCREEN_SIZE - 1);
    localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(COLUMNS);
    localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(COLUMNS - 1);

    localparam int unsigned REQ_W       = 2;
    localparam int unsigned WORD_W      = 16;
    localparam int unsigned IDX_W       = 11;
    localparam int unsigned CURSOR_W    = 11;
    localparam int unsigned DATA_W      = 16;
    localparam int unsigned ATTR_W      = 8;
    localparam int unsigned CHAR_W      = 8;
    localparam int unsigned CFG_IDX_W   = 1;
    localparam int unsigned IN_TDATA_W  = 32;
    localparam int unsigned OUT_TDATA_W = 32;
    localparam int unsigned OUT_PAD_W   = OUT_TDATA_W - CURSOR_W - DATA_W;

    localparam logic [REQ_W-1:0] REQ_PUT   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_ATTR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_ATTR   = 1'b1;

    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;

    localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h07;

    localparam int unsigned       TAB_SPACES    = 4;
    localparam int unsigned       TAB_CNT_W     = $clog2(TAB_SPACES);
    localparam logic [TAB_CNT_W-1:0] LAST_TAB_STEP = TAB_CNT_W'(TAB_SPACES - 1);

    localparam int unsigned QDEPTH = 2;
    localparam int unsigned QPTR_W = $clog2(QDEPTH);

    typedef enum logic [2:0] {
        CMD_CHAR,
        CMD_BS,
        CMD_TAB,
        CMD_LF,
        CMD_CR,
        CMD_CLEAR,
        CMD_READ,
        CMD_NOP
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [WORD_W-1:0]  word;
        logic [ADDR_W-1:0]  addr;
        logic               addr_ok;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic valid;
    } q_status_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_TAB,
        ST_READ,
        ST_SCROLL_MOVE,
        ST_SCROLL_FILL,
        ST_CLEAR
    } back_state_t;

    function automatic logic [WORD_W-1:0] blank_cell(input logic [ATTR_W-1:0] attr);
        return {attr, CH_SPACE};
    endfunction

endpackage

@@ design/text_mode_console_writer_core.sv @@
// Top level of the text mode console writer: configuration registers, front,
// command queue and back. Depends on tmcw_pkg, tmcw_front, tmcw_queue, tmcw_back.
//
// Requests arrive on the s_ stream, one item per request; every item gives
// exactly one result item on the m_ stream with the cursor after the request
// and, for a read, the cell contents. Attributes are set through cfg_we,
// cfg_index and cfg_data; the user must do so only while no request is in
// flight, which the block does not enforce. A two-entry queue sits between the
// decoder and the executing back end, so new items are taken while a result
// waits in the output register. A character, backspace, newline or carriage
// return is executed as the back end takes the command; a read waits for the
// registered memory output, and a tab writes TAB_SPACES blank cells one at a
// time. A scroll walks the screen memory through its single write port,
// copying each cell up one row and then blanking the bottom row. A clear
// writes every cell. After reset the screen memory is filled with blank cells,
// one cell per cycle; s_tready stays low until that pass is done. When the
// receiver stalls, the result holds, the queue fills and s_tready drops once
// it holds two items.
module text_mode_console_writer_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // s_tdata: req_type[1:0], char_word[17:2], cell_index[28:18], zero fill
    input  logic [tmcw_pkg::IN_TDATA_W-1:0]     s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // m_tdata: cursor_pos[10:0], cell_data[26:11], zero fill
    output logic [tmcw_pkg::OUT_TDATA_W-1:0]    m_tdata,
    input  logic                                cfg_we,
    input  logic [tmcw_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tmcw_pkg::ATTR_W-1:0]         cfg_data
);

    logic [tmcw_pkg::ATTR_W-1:0]   default_attr_reg, default_attr_next;
    logic [tmcw_pkg::ATTR_W-1:0]   clear_attr_reg, clear_attr_next;
    logic                          init_busy, push, pop;
    tmcw_pkg::cmd_t                push_cmd, head;
    tmcw_pkg::q_status_t           q_status;
    logic [tmcw_pkg::CURSOR_W-1:0] out_cursor;
    logic [tmcw_pkg::DATA_W-1:0]   out_data;

    always_comb
    begin
        default_attr_next = default_attr_reg;
        clear_attr_next   = clear_attr_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                tmcw_pkg::CFG_DEFAULT_ATTR: default_attr_next = cfg_data;
                tmcw_pkg::CFG_CLEAR_ATTR:   clear_attr_next   = cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_attr_reg <= tmcw_pkg::RESET_ATTR;
            clear_attr_reg   <= tmcw_pkg::RESET_ATTR;
        end
        else
        begin
            default_attr_reg <= default_attr_next;
            clear_attr_reg   <= clear_attr_next;
        end
    end

    tmcw_front u_front (
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .default_attr (default_attr_reg),
        .init_busy    (init_busy),
        .q_status     (q_status),
        .push         (push),
        .cmd          (push_cmd)
    );

    tmcw_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .status   (q_status)
    );

    tmcw_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .default_attr (default_attr_reg),
        .clear_attr   (clear_attr_reg),
        .q_status     (q_status),
        .head         (head),
        .pop          (pop),
        .init_busy    (init_busy),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_cursor   (out_cursor),
        .out_data     (out_data)
    );

    assign m_tdata = {{tmcw_pkg::OUT_PAD_W{1'b0}}, out_data, out_cursor};

endmodule

@@ design/tmcw_queue.sv @@
// Short command queue between the front and the back of the console writer.
// Depends on tmcw_pkg.
module tmcw_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  tmcw_pkg::cmd_t      push_cmd,
    input  logic                pop,
    output tmcw_pkg::cmd_t      head,
    output tmcw_pkg::q_status_t status
);

    tmcw_pkg::cmd_t                  entry_reg [tmcw_pkg::QDEPTH];
    logic [tmcw_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [tmcw_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [tmcw_pkg::QPTR_W:0]       count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + tmcw_pkg::QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + tmcw_pkg::QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + (tmcw_pkg::QPTR_W+1)'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - (tmcw_pkg::QPTR_W+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign head         = entry_reg[rd_ptr_reg];
    assign status.full  = (count_reg == (tmcw_pkg::QPTR_W+1)'(tmcw_pkg::QDEPTH));
    assign status.valid = (count_reg != '0);

endmodule

@@ design/tmcw_front.sv @@
// Front of the console writer: accepts request items and decodes them into
// queue commands with the effective attribute applied. Depends on tmcw_pkg.
module tmcw_front (
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // s_tdata: req_type[1:0], char_word[17:2], cell_index[28:18], zero fill
    input  logic [tmcw_pkg::IN_TDATA_W-1:0]     s_tdata,
    input  logic [tmcw_pkg::ATTR_W-1:0]         default_attr,
    input  logic                                init_busy,
    input  tmcw_pkg::q_status_t                 q_status,
    output logic                                push,
    output tmcw_pkg::cmd_t                      cmd
);

    logic [tmcw_pkg::REQ_W-1:0]  req_type;
    logic [tmcw_pkg::WORD_W-1:0] char_word;
    logic [tmcw_pkg::IDX_W-1:0]  cell_index;
    logic [tmcw_pkg::WORD_W-1:0] eff_word;

    assign req_type   = s_tdata[1:0];
    assign char_word  = s_tdata[17:2];
    assign cell_index = s_tdata[28:18];

    assign eff_word = (char_word[15:8] == '0) ? {default_attr, char_word[7:0]} : char_word;

    assign s_tready = !q_status.full && !init_busy;
    assign push     = s_tvalid && s_tready;

    always_comb
    begin
        cmd.word    = eff_word;
        cmd.addr_ok = (32'(cell_index) < tmcw_pkg::SCREEN_SIZE);
        cmd.addr    = cmd.addr_ok ? tmcw_pkg::ADDR_W'(cell_index) : '0;
        cmd.kind    = tmcw_pkg::CMD_NOP;
        unique case (req_type)
            tmcw_pkg::REQ_PUT:
            begin
                unique case (char_word[7:0])
                    tmcw_pkg::CH_BS:  cmd.kind = tmcw_pkg::CMD_BS;
                    tmcw_pkg::CH_TAB:
                    begin
                        cmd.kind = tmcw_pkg::CMD_TAB;
                        cmd.word = tmcw_pkg::blank_cell(default_attr);
                    end
                    tmcw_pkg::CH_LF:  cmd.kind = tmcw_pkg::CMD_LF;
                    tmcw_pkg::CH_CR:  cmd.kind = tmcw_pkg::CMD_CR;
                    default:          cmd.kind = tmcw_pkg::CMD_CHAR;
                endcase
            end
            tmcw_pkg::REQ_CLEAR: cmd.kind = tmcw_pkg::CMD_CLEAR;
            tmcw_pkg::REQ_READ:  cmd.kind = tmcw_pkg::CMD_READ;
            default:             cmd.kind = tmcw_pkg::CMD_NOP;
        endcase
    end

endmodule

@@ design/tmcw_back.sv @@
// Back of the console writer: holds the screen memory and the cursor, runs
// puts, scrolls, clears and reads, and owns the result register.
// Depends on tmcw_pkg.
module tmcw_back (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [tmcw_pkg::ATTR_W-1:0]        default_attr,
    input  logic [tmcw_pkg::ATTR_W-1:0]        clear_attr,
    input  tmcw_pkg::q_status_t                q_status,
    input  tmcw_pkg::cmd_t                     head,
    output logic                               pop,
    output logic                               init_busy,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [tmcw_pkg::CURSOR_W-1:0]      out_cursor,
    output logic [tmcw_pkg::DATA_W-1:0]        out_data
);

    localparam int unsigned AW = tmcw_pkg::ADDR_W;
    localparam int unsigned CW = tmcw_pkg::COL_W;

    logic [tmcw_pkg::WORD_W-1:0] mem [tmcw_pkg::SCREEN_SIZE];
    logic [tmcw_pkg::WORD_W-1:0] rdata_reg;

    tmcw_pkg::back_state_t state_reg, state_next;

    logic [AW-1:0]                    cursor_reg, cursor_next;
    logic [CW-1:0]                    col_reg, col_next;
    logic [AW-1:0]                    rowbase_reg, rowbase_next;
    logic [AW-1:0]                    fill_addr_reg, fill_addr_next;
    logic [tmcw_pkg::WORD_W-1:0]      fill_word_reg, fill_word_next;
    logic [AW-1:0]                    sc_addr_reg, sc_addr_next;
    logic [AW-1:0]                    wa_reg, wa_next;
    logic                             pend_reg, pend_next;
    logic [tmcw_pkg::TAB_CNT_W-1:0]   tab_cnt_reg, tab_cnt_next;
    logic                             tab_more_reg, tab_more_next;
    logic                             rd_ok_reg, rd_ok_next;
    logic                             out_valid_reg, out_valid_next;
    logic [tmcw_pkg::CURSOR_W-1:0]    out_cursor_reg, out_cursor_next;
    logic [tmcw_pkg::DATA_W-1:0]      out_data_reg, out_data_next;

    logic                             mem_we;
    logic [AW-1:0]                    mem_waddr, mem_raddr;
    logic [tmcw_pkg::WORD_W-1:0]      mem_wdata;

    tmcw_pkg::cmd_kind_t              step_kind;
    logic [tmcw_pkg::WORD_W-1:0]      step_word;
    logic                             step_we, step_scroll;
    logic [AW-1:0]                    step_waddr, step_cursor, step_rowbase;
    logic [tmcw_pkg::WORD_W-1:0]      step_wdata;
    logic [CW-1:0]                    step_col;

    logic                             slot_free, take, emit;
    logic [AW-1:0]                    emit_cursor;
    logic [tmcw_pkg::DATA_W-1:0]      emit_data;

    assign slot_free = !out_valid_reg || out_ready;
    assign take      = (state_reg == tmcw_pkg::ST_IDLE) && q_status.valid && slot_free;

    // One cursor step for a character, backspace, newline or carriage return, or one blank of a tab.
    always_comb
    begin
        step_kind    = (state_reg == tmcw_pkg::ST_TAB) ? tmcw_pkg::CMD_CHAR : head.kind;
        step_word    = (state_reg == tmcw_pkg::ST_TAB) ? tmcw_pkg::blank_cell(default_attr)
                                                       : head.word;
        step_we      = 1'b0;
        step_waddr   = cursor_reg;
        step_wdata   = step_word;
        step_cursor  = cursor_reg;
        step_col     = col_reg;
        step_rowbase = rowbase_reg;
        step_scroll  = 1'b0;
        case (step_kind)
            tmcw_pkg::CMD_CHAR:
            begin
                step_we     = 1'b1;
                step_cursor = cursor_reg + AW'(1);
                step_scroll = (cursor_reg == tmcw_pkg::LAST_CELL);
                if (col_reg == tmcw_pkg::LAST_COL)
                begin
                    step_col     = '0;
                    step_rowbase = rowbase_reg + tmcw_pkg::ROW_STEP;
                end
                else
                begin
                    step_col = col_reg + CW'(1);
                end
            end
            tmcw_pkg::CMD_BS:
            begin
                if (cursor_reg != '0)
                begin
                    step_we     = 1'b1;
                    step_cursor = cursor_reg - AW'(1);
                    step_waddr  = cursor_reg - AW'(1);
                    step_wdata  = tmcw_pkg::blank_cell(step_word[15:8]);
                    if (col_reg == '0)
                    begin
                        step_col     = tmcw_pkg::LAST_COL;
                        step_rowbase = rowbase_reg - tmcw_pkg::ROW_STEP;
                    end
                    else
                    begin
                        step_col = col_reg - CW'(1);
                    end
                end
            end
            tmcw_pkg::CMD_LF:
            begin
                step_scroll  = (rowbase_reg == tmcw_pkg::LAST_ROW);
                step_cursor  = rowbase_reg + tmcw_pkg::ROW_STEP;
                step_rowbase = rowbase_reg + tmcw_pkg::ROW_STEP;
                step_col     = '0;
            end
            tmcw_pkg::CMD_CR:
            begin
                step_cursor = rowbase_reg;
                step_col    = '0;
            end
            default:
            begin
            end
        endcase
        if (step_scroll)
        begin
            step_cursor  = tmcw_pkg::LAST_ROW;
            step_rowbase = tmcw_pkg::LAST_ROW;
            step_col     = '0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tmcw_pkg::ST_INIT:
            begin
                if (fill_addr_reg == tmcw_pkg::LAST_CELL)
                begin
                    state_next = tmcw_pkg::ST_IDLE;
                end
            end
            tmcw_pkg::ST_IDLE:
            begin
                if (take)
                begin
                    case (head.kind) inside
                        tmcw_pkg::CMD_CHAR, tmcw_pkg::CMD_BS, tmcw_pkg::CMD_LF,
                        tmcw_pkg::CMD_CR:
                        begin
                            if (step_scroll)
                            begin
                                state_next = tmcw_pkg::ST_SCROLL_MOVE;
                            end
                        end
                        tmcw_pkg::CMD_TAB:   state_next = tmcw_pkg::ST_TAB;
                        tmcw_pkg::CMD_CLEAR: state_next = tmcw_pkg::ST_CLEAR;
                        tmcw_pkg::CMD_READ:  state_next = tmcw_pkg::ST_READ;
                        default:             state_next = tmcw_pkg::ST_IDLE;
                    endcase
                end
            end
            tmcw_pkg::ST_TAB:
            begin
                if (step_scroll)
                begin
                    state_next = tmcw_pkg::ST_SCROLL_MOVE;
                end
                else if (tab_cnt_reg == tmcw_pkg::LAST_TAB_STEP)
                begin
                    state_next = tmcw_pkg::ST_IDLE;
                end
            end
            tmcw_pkg::ST_READ:
            begin
                state_next = tmcw_pkg::ST_IDLE;
            end
            tmcw_pkg::ST_SCROLL_MOVE:
            begin
                if (sc_addr_reg == tmcw_pkg::LAST_ROW)
                begin
                    state_next = tmcw_pkg::ST_SCROLL_FILL;
                end
            end
            tmcw_pkg::ST_SCROLL_FILL:
            begin
                if (fill_addr_reg == tmcw_pkg::LAST_CELL)
                begin
                    state_next = tab_more_reg ? tmcw_pkg::ST_TAB : tmcw_pkg::ST_IDLE;
                end
            end
            tmcw_pkg::ST_CLEAR:
            begin
                if (fill_addr_reg == tmcw_pkg::LAST_CELL)
                begin
                    state_next = tmcw_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tmcw_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop             = take;
        mem_we          = 1'b0;
        mem_waddr       = fill_addr_reg;
        mem_wdata       = fill_word_reg;
        mem_raddr       = head.addr;
        cursor_next     = cursor_reg;
        col_next        = col_reg;
        rowbase_next    = rowbase_reg;
        fill_addr_next  = fill_addr_reg;
        fill_word_next  = fill_word_reg;
        sc_addr_next    = sc_addr_reg;
        wa_next         = wa_reg;
        pend_next       = 1'b0;
        tab_cnt_next    = tab_cnt_reg;
        tab_more_next   = tab_more_reg;
        rd_ok_next      = rd_ok_reg;
        emit            = 1'b0;
        emit_cursor     = cursor_reg;
        emit_data       = '0;
        unique case (state_reg)
            tmcw_pkg::ST_INIT:
            begin
                mem_we         = 1'b1;
                mem_wdata      = tmcw_pkg::blank_cell(tmcw_pkg::RESET_ATTR);
                fill_addr_next = fill_addr_reg + AW'(1);
            end
            tmcw_pkg::ST_IDLE:
            begin
                if (take)
                begin
                    case (head.kind) inside
                        tmcw_pkg::CMD_CHAR, tmcw_pkg::CMD_BS, tmcw_pkg::CMD_LF,
                        tmcw_pkg::CMD_CR:
                        begin
                            mem_we       = step_we;
                            mem_waddr    = step_waddr;
                            mem_wdata    = step_wdata;
                            cursor_next  = step_cursor;
                            col_next     = step_col;
                            rowbase_next = step_rowbase;
                            if (step_scroll)
                            begin
                                fill_word_next = tmcw_pkg::blank_cell(step_word[15:8]);
                                sc_addr_next   = '0;
                                tab_more_next  = 1'b0;
                            end
                            else
                            begin
                                emit        = 1'b1;
                                emit_cursor = step_cursor;
                            end
                        end
                        tmcw_pkg::CMD_TAB:
                        begin
                            tab_cnt_next = '0;
                        end
                        tmcw_pkg::CMD_CLEAR:
                        begin
                            fill_addr_next = '0;
                            fill_word_next = tmcw_pkg::blank_cell(clear_attr);
                        end
                        tmcw_pkg::CMD_READ:
                        begin
                            rd_ok_next = head.addr_ok;
                        end
                        default:
                        begin
                            emit = 1'b1;
                        end
                    endcase
                end
            end
            tmcw_pkg::ST_TAB:
            begin
                mem_we       = step_we;
                mem_waddr    = step_waddr;
                mem_wdata    = step_wdata;
                cursor_next  = step_cursor;
                col_next     = step_col;
                rowbase_next = step_rowbase;
                tab_cnt_next = tab_cnt_reg + tmcw_pkg::TAB_CNT_W'(1);
                if (step_scroll)
                begin
                    fill_word_next = tmcw_pkg::blank_cell(step_word[15:8]);
                    sc_addr_next   = '0;
                    tab_more_next  = (tab_cnt_reg != tmcw_pkg::LAST_TAB_STEP);
                end
                else if (tab_cnt_reg == tmcw_pkg::LAST_TAB_STEP)
                begin
                    emit        = 1'b1;
                    emit_cursor = step_cursor;
                end
            end
            tmcw_pkg::ST_READ:
            begin
                emit      = 1'b1;
                emit_data = rd_ok_reg ? rdata_reg : '0;
            end
            tmcw_pkg::ST_SCROLL_MOVE:
            begin
                if (sc_addr_reg != tmcw_pkg::LAST_ROW)
                begin
                    mem_raddr    = sc_addr_reg + tmcw_pkg::ROW_STEP;
                    pend_next    = 1'b1;
                    wa_next      = sc_addr_reg;
                    sc_addr_next = sc_addr_reg + AW'(1);
                end
                else
                begin
                    fill_addr_next = tmcw_pkg::LAST_ROW;
                end
            end
            tmcw_pkg::ST_SCROLL_FILL:
            begin
                mem_we         = 1'b1;
                fill_addr_next = fill_addr_reg + AW'(1);
                if (fill_addr_reg == tmcw_pkg::LAST_CELL && !tab_more_reg)
                begin
                    emit = 1'b1;
                end
            end
            tmcw_pkg::ST_CLEAR:
            begin
                mem_we         = 1'b1;
                fill_addr_next = fill_addr_reg + AW'(1);
                if (fill_addr_reg == tmcw_pkg::LAST_CELL)
                begin
                    cursor_next  = '0;
                    col_next     = '0;
                    rowbase_next = '0;
                    emit         = 1'b1;
                    emit_cursor  = '0;
                end
            end
            default:
            begin
            end
        endcase
        // The row copy writes in the cycle after its read, from the registered read data.
        if (pend_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = wa_reg;
            mem_wdata = rdata_reg;
        end
        out_valid_next  = emit || (out_valid_reg && !out_ready);
        out_cursor_next = emit ? tmcw_pkg::CURSOR_W'(emit_cursor) : out_cursor_reg;
        out_data_next   = emit ? emit_data : out_data_reg;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tmcw_pkg::ST_INIT;
            cursor_reg    <= '0;
            col_reg       <= '0;
            rowbase_reg   <= '0;
            fill_addr_reg <= '0;
            sc_addr_reg   <= '0;
            pend_reg      <= 1'b0;
            tab_cnt_reg   <= '0;
            tab_more_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cursor_reg    <= cursor_next;
            col_reg       <= col_next;
            rowbase_reg   <= rowbase_next;
            fill_addr_reg <= fill_addr_next;
            sc_addr_reg   <= sc_addr_next;
            pend_reg      <= pend_next;
            tab_cnt_reg   <= tab_cnt_next;
            tab_more_reg  <= tab_more_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fill_word_reg  <= fill_word_next;
        wa_reg         <= wa_next;
        rd_ok_reg      <= rd_ok_next;
        out_cursor_reg <= out_cursor_next;
        out_data_reg   <= out_data_next;
    end

    assign init_busy  = (state_reg == tmcw_pkg::ST_INIT);
    assign out_valid  = out_valid_reg;
    assign out_cursor = out_cursor_reg;
    assign out_data   = out_data_reg;

endmodule

@@ design/tmcw_checker.sv @@
// Port-level checker for the console writer, bound to the top level.
// Depends on tmcw_pkg and text_mode_console_writer_core_macros.svh.
`include "text_mode_console_writer_core_macros.svh"

module tmcw_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [tmcw_pkg::OUT_TDATA_W-1:0] m_tdata
);

    `TMCW_ASSERT(a_result_held, clk, rst_n, m_tvalid && !m_tready |=> m_tvalid, "result item dropped while stalled")
    `TMCW_ASSERT(a_result_stable, clk, rst_n, m_tvalid && !m_tready |=> $stable(m_tdata), "result item changed while stalled")
    `TMCW_ASSERT(a_cursor_range, clk, rst_n, m_tvalid |-> (tmcw_pkg::SCREEN_SIZE > 2047 || m_tdata[10:0] < 11'(tmcw_pkg::SCREEN_SIZE)), "cursor beyond the screen")
    `TMCW_ASSERT(a_pad_zero, clk, rst_n, m_tvalid |-> m_tdata[31:27] == 5'd0, "fill bits of result not zero")
    `TMCW_ASSERT(a_init_blocks, clk, rst_n, $past(rst_n) == 1'b0 |-> !s_tready, "item accepted before screen initialised")

endmodule

bind text_mode_console_writer_core tmcw_checker u_tmcw_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ verif/testbench.sv @@
// Self-checking bench for text_mode_console_writer_core: puts, clears and reads
// stream through the core while an internal screen image predicts every result.
// Depends on tmcw_pkg and the core RTL only.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tmcw_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNUSED   = 2'd3;
    localparam int unsigned      PHASES       = 6;
    localparam int unsigned      PHASE_ITEMS  = 125;
    localparam int unsigned      SETTLE       = 8;
    localparam int unsigned      CYCLE_LIMIT  = 5_000_000;

    typedef struct {
        logic [REQ_W-1:0]  kind;
        logic [WORD_W-1:0] word;
        logic [IDX_W-1:0]  index;
    } console_req_t;

    typedef struct {
        logic [CURSOR_W-1:0] cursor;
        logic [DATA_W-1:0]   cell_word;
    } console_res_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [ATTR_W-1:0]      cfg_data  = '0;

    console_req_t      request_queue[$];
    console_res_t      awaited_results[$];
    console_req_t      req_on_bus;

    logic [WORD_W-1:0] screen_image [SCREEN_SIZE];
    int unsigned       cursor_image;
    logic [ATTR_W-1:0] default_attr_image;
    logic [ATTR_W-1:0] clear_attr_image;

    int unsigned mismatches    = 0;
    int unsigned results_seen  = 0;
    int unsigned puts_done     = 0;
    int unsigned reads_done    = 0;
    int unsigned clears_done   = 0;
    int unsigned scrolls_done  = 0;
    int unsigned settings_done = 0;
    int unsigned cycle_count   = 0;
    int unsigned send_gap      = 0;
    int unsigned take_stall    = 0;
    int unsigned stall_next;
    bit          send_calm     = 1'b0;
    bit          take_calm     = 1'b0;

    text_mode_console_writer_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic void fill_screen_image(input logic [ATTR_W-1:0] attr);
        int unsigned i;
        for (i = 0; i < SCREEN_SIZE; i++)
            screen_image[i] = {attr, CH_SPACE};
    endfunction

    function automatic void scroll_at_end(input logic [ATTR_W-1:0] attr);
        int unsigned i;
        if (cursor_image < SCREEN_SIZE)
            return;
        for (i = 0; i < SCREEN_SIZE - COLUMNS; i++)
            screen_image[i] = screen_image[i + COLUMNS];
        for (i = SCREEN_SIZE - COLUMNS; i < SCREEN_SIZE; i++)
            screen_image[i] = {attr, CH_SPACE};
        cursor_image -= COLUMNS;
        scrolls_done++;
    endfunction

    function automatic void put_one(input logic [WORD_W-1:0] word);
        logic [CHAR_W-1:0] ch;
        logic [ATTR_W-1:0] attr;
        ch   = word[CHAR_W-1:0];
        attr = word[WORD_W-1:CHAR_W];
        case (ch)
            CH_BS:
            begin
                if (cursor_image > 0)
                begin
                    cursor_image--;
                    screen_image[cursor_image] = {attr, CH_SPACE};
                end
            end
            CH_LF:
                cursor_image = (cursor_image / COLUMNS + 1) * COLUMNS;
            CH_CR:
                cursor_image = cursor_image / COLUMNS * COLUMNS;
            default:
            begin
                if (cursor_image < SCREEN_SIZE)
                    screen_image[cursor_image] = word;
                cursor_image++;
            end
        endcase
        scroll_at_end(attr);
    endfunction

    function automatic console_res_t console_apply(input console_req_t req);
        console_res_t      res;
        logic [WORD_W-1:0] word;
        int unsigned       k;
        res.cell_word = '0;
        case (req.kind)
            REQ_PUT:
            begin
                word = req.word;
                if (word[WORD_W-1:CHAR_W] == '0)
                    word[WORD_W-1:CHAR_W] = default_attr_image;
                if (word[CHAR_W-1:0] == CH_TAB)
                begin
                    for (k = 0; k < TAB_SPACES; k++)
                        put_one({default_attr_image, CH_SPACE});
                end
                else
                    put_one(word);
                puts_done++;
            end
            REQ_CLEAR:
            begin
                fill_screen_image(clear_attr_image);
                cursor_image = 0;
                clears_done++;
            end
            REQ_READ:
            begin
                if (req.index < SCREEN_SIZE)
                    res.cell_word = screen_image[req.index];
                reads_done++;
            end
            default:
                ;
        endcase
        res.cursor = cursor_image[CURSOR_W-1:0];
        return res;
    endfunction

    function automatic int unsigned draw_wait(inout bit calm);
        if ($urandom_range(0, 39) == 0)
            calm = !calm;
        return calm ? 0 : $urandom_range(0, 5);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        mismatches++;
        $display("[%0t] result %0d: %s expected 0x%0h, got 0x%0h",
                 $time, results_seen, what, want, got);
    endtask

    task automatic check_result(input logic [OUT_TDATA_W-1:0] data);
        console_res_t want;
        results_seen++;
        if (awaited_results.size() == 0)
        begin
            report_mismatch("result with nothing awaited", '0, data);
            return;
        end
        want = awaited_results.pop_front();
        if (data[CURSOR_W-1:0] !== want.cursor)
            report_mismatch("cursor_pos", want.cursor, data[CURSOR_W-1:0]);
        if (data[CURSOR_W+DATA_W-1:CURSOR_W] !== want.cell_word)
            report_mismatch("cell_data", want.cell_word, data[CURSOR_W+DATA_W-1:CURSOR_W]);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            send_gap <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                awaited_results.push_back(console_apply(req_on_bus));
            if (!s_tvalid || s_tready)
            begin
                if (send_gap > 0)
                begin
                    s_tvalid <= 1'b0;
                    send_gap <= send_gap - 1;
                end
                else if (request_queue.size() > 0)
                begin
                    req_on_bus = request_queue.pop_front();
                    s_tdata    <= IN_TDATA_W'({req_on_bus.index, req_on_bus.word,
                                               req_on_bus.kind});
                    s_tvalid   <= 1'b1;
                    send_gap   <= draw_wait(send_calm);
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            take_stall <= 0;
        end
        else
        begin
            stall_next = take_stall;
            if (m_tvalid && m_tready)
            begin
                check_result(m_tdata);
                stall_next = draw_wait(take_calm);
            end
            if (stall_next > 0)
            begin
                m_tready   <= 1'b0;
                take_stall <= stall_next - 1;
            end
            else
            begin
                m_tready   <= 1'b1;
                take_stall <= 0;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Run stopped after %0d cycles with %0d results outstanding.",
                     cycle_count, awaited_results.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic void push_req(input logic [REQ_W-1:0] kind,
                                     input logic [WORD_W-1:0] word,
                                     input int unsigned index);
        console_req_t req;
        req.kind  = kind;
        req.word  = word;
        req.index = IDX_W'(index);
        request_queue.push_back(req);
    endfunction

    function automatic logic [ATTR_W-1:0] random_attr();
        return ($urandom_range(0, 3) == 0) ? '0 : ATTR_W'($urandom);
    endfunction

    function automatic int unsigned random_index();
        return $urandom_range(0, (1 << IDX_W) - 1);
    endfunction

    // Mostly text, control characters, reads, clears and unused requests; now and
    // then a run of newlines drives the cursor to the bottom to exercise scrolling.
    function automatic int unsigned queue_random_run();
        int unsigned pick;
        int unsigned n;
        int unsigned i;
        pick = $urandom_range(0, 99);
        if (pick < 3)
        begin
            n = $urandom_range(5, 25);
            for (i = 0; i < n; i++)
                push_req(REQ_PUT, {random_attr(), CH_LF}, random_index());
            return n;
        end
        if (pick < 50)
            push_req(REQ_PUT, {random_attr(), CHAR_W'($urandom_range(8'h21, 8'h7e))},
                     random_index());
        else if (pick < 58)
            push_req(REQ_PUT, WORD_W'($urandom), random_index());
        else if (pick < 67)
            push_req(REQ_PUT, {random_attr(), CH_LF}, random_index());
        else if (pick < 70)
            push_req(REQ_PUT, {random_attr(), CH_CR}, random_index());
        else if (pick < 74)
            push_req(REQ_PUT, {random_attr(), CH_BS}, random_index());
        else if (pick < 78)
            push_req(REQ_PUT, {random_attr(), CH_TAB}, random_index());
        else if (pick < 96)
            push_req(REQ_READ, WORD_W'($urandom), random_index());
        else if (pick < 98)
            push_req(REQ_CLEAR, WORD_W'($urandom), random_index());
        else
            push_req(REQ_UNUSED, WORD_W'($urandom), random_index());
        return 1;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [ATTR_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (index == CFG_DEFAULT_ATTR)
            default_attr_image = value;
        else
            clear_attr_image = value;
        settings_done++;
    endtask

    task automatic wait_for_drain();
        @(negedge clk);
        while (request_queue.size() != 0 || s_tvalid || awaited_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    initial
    begin
        int unsigned       phase;
        int unsigned       made;
        logic [ATTR_W-1:0] dflt_setting;
        logic [ATTR_W-1:0] clr_setting;

        fill_screen_image(RESET_ATTR);
        cursor_image       = 0;
        default_attr_image = RESET_ATTR;
        clear_attr_image   = RESET_ATTR;

        push_req(REQ_READ, 16'h0000, 0);
        push_req(REQ_READ, 16'h0000, SCREEN_SIZE - 1);
        push_req(REQ_READ, 16'h0000, (1 << IDX_W) - 1);
        push_req(REQ_READ, 16'h0000, SCREEN_SIZE);
        push_req(REQ_PUT, {8'h00, CH_BS}, 0);
        push_req(REQ_PUT, 16'h0041, 0);
        push_req(REQ_PUT, 16'hffff, 0);
        push_req(REQ_PUT, 16'h0000, 0);
        push_req(REQ_PUT, {8'h1e, CH_BS}, 0);
        push_req(REQ_PUT, {8'h00, CH_TAB}, 0);
        push_req(REQ_PUT, {8'h4f, CH_TAB}, 0);
        push_req(REQ_PUT, {8'h3c, CH_CR}, 0);
        push_req(REQ_PUT, {8'h00, CH_LF}, 0);
        push_req(REQ_PUT, {8'h55, CH_LF}, 0);
        push_req(REQ_PUT, 16'h7f7e, 0);
        push_req(REQ_UNUSED, 16'hffff, (1 << IDX_W) - 1);
        push_req(REQ_READ, 16'h0000, 0);
        push_req(REQ_READ, 16'h0000, 1);
        push_req(REQ_READ, 16'h0000, 2);
        push_req(REQ_READ, 16'h0000, 4);
        push_req(REQ_READ, 16'h0000, COLUMNS);
        push_req(REQ_CLEAR, 16'h0000, 0);
        push_req(REQ_READ, 16'h0000, 0);
        push_req(REQ_READ, 16'h0000, SCREEN_SIZE - 1);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        wait_for_drain();

        for (phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:       begin dflt_setting = 8'h00; clr_setting = 8'h00; end
                1:       begin dflt_setting = 8'hff; clr_setting = 8'hff; end
                2:       begin dflt_setting = 8'h1f; clr_setting = 8'h70; end
                3:       begin dflt_setting = random_attr(); clr_setting = 8'h00; end
                4:       begin dflt_setting = 8'hff; clr_setting = ATTR_W'($urandom); end
                default: begin dflt_setting = ATTR_W'($urandom); clr_setting = ATTR_W'($urandom); end
            endcase
            write_reg(CFG_DEFAULT_ATTR, dflt_setting);
            write_reg(CFG_CLEAR_ATTR, clr_setting);
            @(negedge clk);
            made = 0;
            while (made < PHASE_ITEMS)
                made += queue_random_run();
            wait_for_drain();
        end

        $display("Ran %0d requests: %0d puts, %0d reads, %0d clears, %0d scrolls.",
                 results_seen, puts_done, reads_done, clears_done, scrolls_done);
        $display("Attribute registers written %0d times; %0d mismatches.",
                 settings_done, mismatches);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+design
design/tmcw_pkg.sv
design/tmcw_queue.sv
design/tmcw_front.sv
design/tmcw_back.sv
design/text_mode_console_writer_core.sv
design/tmcw_checker.sv
verif/testbench.sv
